// ----- design/ocl_pkg.sv -----
// ----------------------------------------------------------------------------
// ocl_pkg
// shared types, codes and helpers of the ordered coordinate list
// ----------------------------------------------------------------------------
package ocl_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BYTES = 8;

    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int COORD_W   = 16;
    localparam int TAG_W     = 64;
    localparam int POS_W     = 4;
    localparam int CNT_OUT_W = 5;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT  = 3'd0,
        OP_ADD_BACK   = 3'd1,
        OP_TAKE_FRONT = 3'd2,
        OP_TAKE_BACK  = 3'd3,
        OP_FIND_XY    = 3'd4,
        OP_FIND_TAG   = 3'd5,
        OP_ERASE      = 3'd6,
        OP_NOP        = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_SHIFT,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TAG_W-1:0]          tag;
    } entry_t;

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TAG_W-1:0]          tag;
        logic [POS_W-1:0]          position;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        entry_t                entry;
        logic [POS_W-1:0]      found_position;
        logic [CNT_OUT_W-1:0]  entry_count;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // keep bytes up to the first zero byte, at most limit of them
    function automatic logic [TAG_W-1:0] tag_norm(input logic [TAG_W-1:0] t,
                                                  input int limit);
        logic [TAG_W-1:0] r;
        logic             stop;
        logic [7:0]       b;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < TAG_W / 8; i++)
        begin
            b = t[8*i +: 8];
            if (i >= limit || b == 8'd0)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                r[8*i +: 8] = b;
            end
        end
        return r;
    endfunction

    // circular buffer address of a sequence position
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [ADDR_W-1:0] idx);
        logic [ADDR_W:0] s;
        s = {1'b0, head} + {1'b0, idx};
        if (s >= (ADDR_W+1)'(DEPTH))
        begin
            s = s - (ADDR_W+1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] head_inc(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] r;
        if (head == ADDR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = head + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] head_dec(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] r;
        if (head == '0)
        begin
            r = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            r = head - 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- design/ocl_cmd_if.sv -----
// ----------------------------------------------------------------------------
// ocl_cmd_if
// command channel of the ordered coordinate list
// ----------------------------------------------------------------------------
interface ocl_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [ocl_pkg::OP_W-1:0]            op;
    logic signed [ocl_pkg::COORD_W-1:0]  x;
    logic signed [ocl_pkg::COORD_W-1:0]  y;
    logic [ocl_pkg::TAG_W-1:0]           tag;
    logic [ocl_pkg::POS_W-1:0]           position;

    modport source (output valid, op, x, y, tag, position, input ready);
    modport sink   (input valid, op, x, y, tag, position, output ready);
endinterface

// ----- design/ocl_res_if.sv -----
// ----------------------------------------------------------------------------
// ocl_res_if
// result channel of the ordered coordinate list
// ----------------------------------------------------------------------------
interface ocl_res_if;
    logic                                valid;
    logic                                ready;
    logic [ocl_pkg::STATUS_W-1:0]        status;
    logic signed [ocl_pkg::COORD_W-1:0]  out_x;
    logic signed [ocl_pkg::COORD_W-1:0]  out_y;
    logic [ocl_pkg::TAG_W-1:0]           out_tag;
    logic [ocl_pkg::POS_W-1:0]           found_position;
    logic [ocl_pkg::CNT_OUT_W-1:0]       entry_count;

    modport source (output valid, status, out_x, out_y, out_tag, found_position,
                    entry_count, input ready);
    modport sink   (input valid, status, out_x, out_y, out_tag, found_position,
                    entry_count, output ready);
endinterface

// ----- design/ocl_store.sv -----
// ----------------------------------------------------------------------------
// ocl_store
// entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ocl_store
(
    input  logic               clk,
    input  ocl_pkg::mem_req_t  req,
    output ocl_pkg::entry_t    rdata
);

    ocl_pkg::entry_t mem [ocl_pkg::DEPTH];
    ocl_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/ocl_seq.sv -----
// ----------------------------------------------------------------------------
// ocl_seq
// sequencer: head and count, walks the entry memory for search and erase
// ----------------------------------------------------------------------------
module ocl_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ocl_pkg::cmd_t      cmd_item,
    output logic               emit_valid,
    input  logic               emit_ready,
    output ocl_pkg::res_t      emit_item,
    output ocl_pkg::mem_req_t  mem_req,
    input  ocl_pkg::entry_t    mem_rdata
);

    ocl_pkg::state_t                 state_reg, state_next;
    logic [ocl_pkg::ADDR_W-1:0]      head_reg, head_next;
    logic [ocl_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [ocl_pkg::ADDR_W-1:0]      idx_reg, idx_next;
    ocl_pkg::op_t                    op_reg, op_next;
    ocl_pkg::entry_t                 want_reg, want_next;
    ocl_pkg::res_t                   res_reg, res_next;

    logic                            full;
    logic                            empty;
    logic                            pos_bad;
    logic                            at_last;
    logic                            hit;
    logic [ocl_pkg::ADDR_W-1:0]      last_idx;
    logic [ocl_pkg::ADDR_W-1:0]      idx_inc;
    ocl_pkg::entry_t                 new_entry;

    assign full     = (count_reg == ocl_pkg::CNT_W'(ocl_pkg::DEPTH));
    assign empty    = (count_reg == '0);
    assign pos_bad  = (32'(cmd_item.position) >= 32'(count_reg));
    assign last_idx = ocl_pkg::ADDR_W'(count_reg - 1'b1);
    assign at_last  = (idx_reg == last_idx);
    assign idx_inc  = idx_reg + 1'b1;
    assign hit      = (op_reg == ocl_pkg::OP_FIND_XY)
                      ? (mem_rdata.x == want_reg.x && mem_rdata.y == want_reg.y)
                      : (mem_rdata.tag == want_reg.tag);

    always_comb
    begin
        new_entry.x   = cmd_item.x;
        new_entry.y   = cmd_item.y;
        new_entry.tag = ocl_pkg::tag_norm(cmd_item.tag, ocl_pkg::TAG_BYTES - 1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ocl_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_item.op)
                        ocl_pkg::OP_TAKE_FRONT,
                        ocl_pkg::OP_TAKE_BACK:
                            state_next = empty ? ocl_pkg::S_EMIT : ocl_pkg::S_FETCH;
                        ocl_pkg::OP_ERASE:
                            state_next = pos_bad ? ocl_pkg::S_EMIT : ocl_pkg::S_FETCH;
                        ocl_pkg::OP_FIND_XY,
                        ocl_pkg::OP_FIND_TAG:
                            state_next = empty ? ocl_pkg::S_EMIT : ocl_pkg::S_SCAN;
                        default:
                            state_next = ocl_pkg::S_EMIT;
                    endcase
                end
            end
            ocl_pkg::S_FETCH:
            begin
                if (op_reg == ocl_pkg::OP_ERASE && !at_last)
                begin
                    state_next = ocl_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = ocl_pkg::S_EMIT;
                end
            end
            ocl_pkg::S_SHIFT:
            begin
                if (at_last)
                begin
                    state_next = ocl_pkg::S_EMIT;
                end
            end
            ocl_pkg::S_SCAN:
            begin
                if (hit || at_last)
                begin
                    state_next = ocl_pkg::S_EMIT;
                end
            end
            ocl_pkg::S_EMIT:
            begin
                if (emit_ready)
                begin
                    state_next = ocl_pkg::S_IDLE;
                end
            end
            default:
                state_next = ocl_pkg::S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        want_next  = want_reg;
        res_next   = res_reg;
        mem_req    = '0;
        cmd_ready  = (state_reg == ocl_pkg::S_IDLE);
        emit_valid = (state_reg == ocl_pkg::S_EMIT);
        emit_item  = res_reg;

        case (state_reg)
            ocl_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next       = cmd_item.op;
                    want_next.x   = cmd_item.x;
                    want_next.y   = cmd_item.y;
                    want_next.tag = ocl_pkg::tag_norm(cmd_item.tag, ocl_pkg::TAG_W / 8);
                    res_next      = '0;
                    res_next.status      = ocl_pkg::ST_OK;
                    res_next.entry_count = ocl_pkg::CNT_OUT_W'(count_reg);
                    case (cmd_item.op)
                        ocl_pkg::OP_ADD_FRONT,
                        ocl_pkg::OP_ADD_BACK:
                        begin
                            if (full)
                            begin
                                res_next.status = ocl_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.wdata = new_entry;
                                if (cmd_item.op == ocl_pkg::OP_ADD_FRONT)
                                begin
                                    head_next     = ocl_pkg::head_dec(head_reg);
                                    mem_req.waddr = ocl_pkg::head_dec(head_reg);
                                    res_next.found_position = '0;
                                end
                                else
                                begin
                                    mem_req.waddr = ocl_pkg::phys_addr(head_reg,
                                                        ocl_pkg::ADDR_W'(count_reg));
                                    res_next.found_position =
                                        ocl_pkg::POS_W'(count_reg);
                                end
                                count_next           = count_reg + 1'b1;
                                res_next.entry       = new_entry;
                                res_next.entry_count =
                                    ocl_pkg::CNT_OUT_W'(count_reg + 1'b1);
                            end
                        end
                        ocl_pkg::OP_TAKE_FRONT,
                        ocl_pkg::OP_TAKE_BACK:
                        begin
                            if (empty)
                            begin
                                res_next.status = ocl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next = (cmd_item.op == ocl_pkg::OP_TAKE_FRONT)
                                           ? '0 : last_idx;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ocl_pkg::phys_addr(head_reg, idx_next);
                            end
                        end
                        ocl_pkg::OP_ERASE:
                        begin
                            if (pos_bad)
                            begin
                                res_next.status = ocl_pkg::ST_RANGE;
                            end
                            else
                            begin
                                idx_next      = ocl_pkg::ADDR_W'(cmd_item.position);
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ocl_pkg::phys_addr(head_reg, idx_next);
                            end
                        end
                        ocl_pkg::OP_FIND_XY,
                        ocl_pkg::OP_FIND_TAG:
                        begin
                            if (empty)
                            begin
                                res_next.status = ocl_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                idx_next      = '0;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = head_reg;
                            end
                        end
                        default:
                        begin
                            res_next.status = ocl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            ocl_pkg::S_FETCH:
            begin
                res_next.status         = ocl_pkg::ST_OK;
                res_next.entry          = mem_rdata;
                res_next.found_position = ocl_pkg::POS_W'(idx_reg);
                res_next.entry_count    = ocl_pkg::CNT_OUT_W'(count_reg - 1'b1);
                if (op_reg == ocl_pkg::OP_TAKE_FRONT)
                begin
                    head_next  = ocl_pkg::head_inc(head_reg);
                    count_next = count_reg - 1'b1;
                end
                else if (op_reg != ocl_pkg::OP_ERASE || at_last)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    idx_next      = idx_inc;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ocl_pkg::phys_addr(head_reg, idx_inc);
                end
            end
            ocl_pkg::S_SHIFT:
            begin
                // move entry idx down by one; read and write addresses never meet
                mem_req.we    = 1'b1;
                mem_req.waddr = ocl_pkg::phys_addr(head_reg, idx_reg - 1'b1);
                mem_req.wdata = mem_rdata;
                if (at_last)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    idx_next      = idx_inc;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ocl_pkg::phys_addr(head_reg, idx_inc);
                end
            end
            ocl_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    res_next.status         = ocl_pkg::ST_OK;
                    res_next.entry          = mem_rdata;
                    res_next.found_position = ocl_pkg::POS_W'(idx_reg);
                end
                else if (at_last)
                begin
                    res_next.status         = ocl_pkg::ST_NOT_FOUND;
                    res_next.entry          = '0;
                    res_next.found_position = '0;
                end
                else
                begin
                    idx_next      = idx_inc;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ocl_pkg::phys_addr(head_reg, idx_inc);
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ocl_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        want_reg <= want_next;
        res_reg  <= res_next;
    end

endmodule

// ----- design/ordered_coordinate_list_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_coordinate_list_unit
// double-ended list of coordinate entries with search and erase by position
// ----------------------------------------------------------------------------
// The list holds up to 16 entries (x, y, tag) in a circular buffer held in one
// synchronous memory; a head pointer and a count give the sequence order. One
// command item is worked on at a time and each gives exactly one result item.
// Adds and error cases go from acceptance straight to the result register;
// takes first read the entry; a search reads one entry per cycle from the
// front and stops at the first hit or at the last entry; an erase at
// position p reads the entry and then moves each later entry down by one.
// The single memory read port gives one entry per cycle.
// A result sits in an output register, so the next command is taken while it
// waits. Entry memory needs no clearing after reset: only entries below the
// count are ever read.
module ordered_coordinate_list_unit
(
    input  logic       clk,
    input  logic       rst_n,
    ocl_cmd_if.sink    cmd,
    ocl_res_if.source  res
);

    ocl_pkg::cmd_t      cmd_item;
    ocl_pkg::res_t      emit_item;
    ocl_pkg::mem_req_t  mem_req;
    ocl_pkg::entry_t    mem_rdata;
    logic               emit_valid;
    logic               emit_ready;

    // output stage
    logic               out_valid_reg, out_valid_next;
    ocl_pkg::res_t      out_item_reg;

    always_comb
    begin
        cmd_item.op       = ocl_pkg::op_t'(cmd.op);
        cmd_item.x        = cmd.x;
        cmd_item.y        = cmd.y;
        cmd_item.tag      = cmd.tag;
        cmd_item.position = cmd.position;
    end

    ocl_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_ready  (cmd.ready),
        .cmd_item   (cmd_item),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_item  (emit_item),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    ocl_store u_store
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // result register is free when empty or being taken this cycle
    assign emit_ready = !out_valid_reg || res.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_valid && emit_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ready)
        begin
            out_item_reg <= emit_item;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.status         = out_item_reg.status;
    assign res.out_x          = out_item_reg.entry.x;
    assign res.out_y          = out_item_reg.entry.y;
    assign res.out_tag        = out_item_reg.entry.tag;
    assign res.found_position = out_item_reg.found_position;
    assign res.entry_count    = out_item_reg.entry_count;

endmodule

// ----- sim/tb_ordered_coordinate_list_unit.sv -----
// ----------------------------------------------------------------------------
// tb_ordered_coordinate_list_unit
// self-checking bench for the ordered coordinate list
// ----------------------------------------------------------------------------
// Commands go in on the cmd channel and results come back on the res channel,
// one result per command. A mirror of the list is kept as a queue of entries
// and updated at every accepted command. The result this predicts is queued,
// and each returned result is checked field by field against the oldest one.
// The stimulus runs in steps: edge cases, a fill to capacity and a drain, random
// mixes under four idle/stall patterns, and a long output hold that backs up
// the input side.
// ----------------------------------------------------------------------------
module tb_ordered_coordinate_list_unit;

    import ocl_pkg::*;

    // bench limits
    localparam int LONG_HOLD    = 300;   // cycles the receiver holds off under pressure
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 40;    // settle time after the last result
    localparam int MIX_SPAN     = 40;    // items per random op mix
    localparam int MAX_PRINTS   = 50;

    // op mixes that steer the fill level up, down or keep it level
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } mix_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ocl_cmd_if cmd_ch ();
    ocl_res_if res_ch ();

    ordered_coordinate_list_unit DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    // mirror of the list contents, front at index 0
    entry_t list_mirror[$];
    // results predicted for accepted commands, oldest first
    res_t   pending_results[$];

    // idle settings, written by the test tasks
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    // each increment asks the receiver for one long hold
    int hold_requests   = 0;

    // run statistics
    int err_count       = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int full_adds       = 0;
    int empty_takes     = 0;
    int search_misses   = 0;
    int range_erases    = 0;
    int peak_fill       = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // keep the leading nonzero bytes of a tag, at most max_bytes of them
    function automatic logic [TAG_W-1:0] trim_tag(input logic [TAG_W-1:0] t,
                                                  input int max_bytes);
        logic [TAG_W-1:0] kept;
        kept = '0;
        for (int k = 0; k < max_bytes && k < TAG_W / 8; k++)
        begin
            if (t[8*k +: 8] == 8'h00)
            begin
                break;
            end
            kept[8*k +: 8] = t[8*k +: 8];
        end
        return kept;
    endfunction

    // apply one command to the mirror and return the result it should give
    function automatic res_t apply_list_op(input cmd_t c);
        res_t             r;
        entry_t           e;
        int               idx;
        logic [TAG_W-1:0] want_tag;
        r        = '0;
        r.status = ST_OK;
        idx      = -1;
        case (c.op)
            OP_ADD_FRONT, OP_ADD_BACK:
            begin
                if (list_mirror.size() >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    e.x   = c.x;
                    e.y   = c.y;
                    e.tag = trim_tag(c.tag, TAG_BYTES - 1);
                    if (c.op == OP_ADD_FRONT)
                    begin
                        list_mirror.push_front(e);
                        idx = 0;
                    end
                    else
                    begin
                        list_mirror.push_back(e);
                        idx = list_mirror.size() - 1;
                    end
                    r.entry          = e;
                    r.found_position = POS_W'(idx);
                end
            end
            OP_TAKE_FRONT, OP_TAKE_BACK, OP_ERASE:
            begin
                if (c.op == OP_ERASE)
                begin
                    if (int'(c.position) >= list_mirror.size())
                    begin
                        r.status = ST_RANGE;
                    end
                    else
                    begin
                        idx = int'(c.position);
                    end
                end
                else if (list_mirror.size() == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    idx = (c.op == OP_TAKE_FRONT) ? 0 : list_mirror.size() - 1;
                end
                if (idx >= 0)
                begin
                    r.entry          = list_mirror[idx];
                    r.found_position = POS_W'(idx);
                    list_mirror.delete(idx);
                end
            end
            OP_FIND_XY, OP_FIND_TAG:
            begin
                // the search key is not truncated, so an eight byte tag never hits
                want_tag = trim_tag(c.tag, TAG_W / 8);
                r.status = ST_NOT_FOUND;
                for (int k = 0; k < list_mirror.size(); k++)
                begin
                    if ((c.op == OP_FIND_XY &&
                         list_mirror[k].x == c.x && list_mirror[k].y == c.y) ||
                        (c.op == OP_FIND_TAG && list_mirror[k].tag == want_tag))
                    begin
                        r.status         = ST_OK;
                        r.entry          = list_mirror[k];
                        r.found_position = POS_W'(k);
                        break;
                    end
                end
            end
            default:
            begin
                // no-op: status ok with the count only
            end
        endcase
        r.entry_count = CNT_OUT_W'(list_mirror.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [TAG_W-1:0] got,
                                   input logic [TAG_W-1:0] want);
        if (err_count < MAX_PRINTS)
        begin
            $display("mismatch at result %0d: %s got %h expected %h",
                     results_checked, what, got, want);
        end
        err_count++;
    endtask

    task automatic check_result(input res_t want);
        if (res_ch.status !== want.status)
        begin
            report_mismatch("status", res_ch.status, want.status);
        end
        if (res_ch.out_x !== want.entry.x)
        begin
            report_mismatch("out_x", res_ch.out_x, want.entry.x);
        end
        if (res_ch.out_y !== want.entry.y)
        begin
            report_mismatch("out_y", res_ch.out_y, want.entry.y);
        end
        if (res_ch.out_tag !== want.entry.tag)
        begin
            report_mismatch("out_tag", res_ch.out_tag, want.entry.tag);
        end
        if (res_ch.found_position !== want.found_position)
        begin
            report_mismatch("found_position", res_ch.found_position, want.found_position);
        end
        if (res_ch.entry_count !== want.entry_count)
        begin
            report_mismatch("entry_count", res_ch.entry_count, want.entry_count);
        end
    endtask

    // watch both channels: predict on every accepted command, check every result
    always @(posedge clk)
    begin
        cmd_t seen;
        res_t predicted;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen.op       = op_t'(cmd_ch.op);
                seen.x        = cmd_ch.x;
                seen.y        = cmd_ch.y;
                seen.tag      = cmd_ch.tag;
                seen.position = cmd_ch.position;
                predicted     = apply_list_op(seen);
                pending_results.push_back(predicted);
                items_accepted++;
                if (list_mirror.size() > peak_fill)
                begin
                    peak_fill = list_mirror.size();
                end
                case (predicted.status)
                    ST_FULL:      full_adds++;
                    ST_EMPTY:     empty_takes++;
                    ST_NOT_FOUND: search_misses++;
                    ST_RANGE:     range_erases++;
                    default:      ;
                endcase
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, status", res_ch.status, '0);
                end
                else
                begin
                    check_result(pending_results.pop_front());
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls plus an occasional long hold
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: the run stops if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet, pending_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // offer one command and hold it until accepted; valid stays high afterwards
    // so back-to-back items need no extra edge
    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.op       <= c.op;
        cmd_ch.x        <= c.x;
        cmd_ch.y        <= c.y;
        cmd_ch.tag      <= c.tag;
        cmd_ch.position <= c.position;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
    endtask

    task automatic send_fields(input op_t op, input int x, input int y,
                               input logic [TAG_W-1:0] tag, input int position);
        cmd_t c;
        c.op       = op;
        c.x        = COORD_W'(x);
        c.y        = COORD_W'(y);
        c.tag      = tag;
        c.position = POS_W'(position);
        send_cmd(c);
    endtask

    // tag of len nonzero bytes, optionally with junk past the terminator
    function automatic logic [TAG_W-1:0] rand_tag(input int len, input bit junk);
        logic [TAG_W-1:0] t;
        t = '0;
        for (int k = 0; k < TAG_W / 8; k++)
        begin
            if (k < len)
            begin
                t[8*k +: 8] = 8'($urandom_range(255, 1));
            end
            else if (k > len && junk)
            begin
                t[8*k +: 8] = 8'($urandom_range(255));
            end
        end
        return t;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] v;
        case ($urandom_range(9))
            0:       v = 16'h8000;
            1:       v = 16'h7fff;
            2:       v = 16'h0000;
            3:       v = 16'hffff;
            default: v = COORD_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic op_t pick_op(input mix_t mix);
        op_t order[7];
        int  cut[7];
        int  r;
        order = '{OP_ADD_FRONT, OP_ADD_BACK, OP_TAKE_FRONT, OP_TAKE_BACK,
                  OP_FIND_XY, OP_FIND_TAG, OP_ERASE};
        case (mix)
            MIX_GROW:   cut = '{25, 50, 57, 64, 76, 88, 96};
            MIX_SHRINK: cut = '{8, 16, 36, 56, 68, 80, 96};
            default:    cut = '{15, 30, 42, 54, 68, 82, 96};
        endcase
        r = $urandom_range(99);
        for (int k = 0; k < 7; k++)
        begin
            if (r < cut[k])
            begin
                return order[k];
            end
        end
        return OP_NOP;
    endfunction

    // random command whose contents often point at what is stored, so that
    // searches hit, duplicates exist and erases land in range
    function automatic cmd_t rand_cmd(input op_t op);
        cmd_t             c;
        entry_t           pick;
        int               n;
        int               r;
        int               stop_at;
        c.op       = op;
        c.x        = rand_coord();
        c.y        = rand_coord();
        c.tag      = rand_tag($urandom_range(TAG_W / 8), $urandom_range(1));
        c.position = POS_W'($urandom_range(15));
        n          = list_mirror.size();
        r          = $urandom_range(99);
        if (n > 0)
        begin
            pick = list_mirror[$urandom_range(n - 1)];
            case (op)
                OP_ADD_FRONT, OP_ADD_BACK:
                begin
                    // duplicates make the first-match rule visible
                    if (r < 20)
                    begin
                        c.x   = pick.x;
                        c.y   = pick.y;
                        c.tag = pick.tag;
                    end
                end
                OP_FIND_XY:
                begin
                    if (r < 60)
                    begin
                        c.x = pick.x;
                        c.y = pick.y;
                    end
                    else if (r < 75)
                    begin
                        c.x = pick.x;
                    end
                end
                OP_FIND_TAG:
                begin
                    if (r < 60)
                    begin
                        c.tag   = pick.tag;
                        stop_at = TAG_W / 8;
                        for (int k = 0; k < TAG_W / 8; k++)
                        begin
                            if (pick.tag[8*k +: 8] == 8'h00 && stop_at == TAG_W / 8)
                            begin
                                stop_at = k;
                            end
                        end
                        // junk past the terminator must not spoil the match
                        if (r < 30)
                        begin
                            for (int k = stop_at + 1; k < TAG_W / 8; k++)
                            begin
                                c.tag[8*k +: 8] = 8'($urandom_range(255));
                            end
                        end
                    end
                end
                OP_ERASE:
                begin
                    if (r < 70)
                    begin
                        c.position = POS_W'($urandom_range(n - 1));
                    end
                end
                default: ;
            endcase
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty-list errors, coordinate and tag extremes, tag trimming and
    // matching rules, erase in and out of range, no-op
    task automatic test_edge_cases();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        // everything on an empty list
        send_fields(OP_TAKE_FRONT, 0, 0, '0, 0);
        send_fields(OP_TAKE_BACK, 0, 0, '0, 0);
        send_fields(OP_ERASE, 0, 0, '0, 0);
        send_fields(OP_FIND_XY, 0, 0, '0, 0);
        send_fields(OP_FIND_TAG, 0, 0, '0, 0);
        send_fields(OP_NOP, -1, -1, '1, 15);
        // all-ones tag loses its last byte, a middle zero ends the tag
        send_fields(OP_ADD_BACK, 32767, -32768, 64'hffff_ffff_ffff_ffff, 15);
        send_fields(OP_ADD_FRONT, -32768, 32767, 64'hdead_beef_5a00_6261, 0);
        send_fields(OP_ADD_BACK, 0, 0, 64'h0, 0);
        send_fields(OP_ADD_FRONT, -1, 1, 64'h0807_0605_0403_0201, 0);
        // searches
        send_fields(OP_FIND_XY, 0, 0, '0, 0);
        send_fields(OP_FIND_XY, -1, -1, '0, 0);
        send_fields(OP_FIND_TAG, 0, 0, 64'hffff_ffff_ffff_ffff, 0);
        send_fields(OP_FIND_TAG, 0, 0, 64'h00ff_ffff_ffff_ffff, 0);
        send_fields(OP_FIND_TAG, 0, 0, 64'h1234_5678_9a00_6261, 0);
        send_fields(OP_FIND_TAG, 0, 0, 64'h0, 0);
        send_fields(OP_FIND_TAG, 0, 0, 64'h0007_0605_0403_0201, 0);
        // erase out of range, in the middle, at the back
        send_fields(OP_ERASE, 0, 0, '0, 15);
        send_fields(OP_ERASE, 0, 0, '0, 1);
        send_fields(OP_ERASE, 0, 0, '0, 2);
        send_fields(OP_NOP, 0, 0, '0, 0);
        // drain and go one past empty
        send_fields(OP_TAKE_BACK, 0, 0, '0, 0);
        send_fields(OP_TAKE_FRONT, 0, 0, '0, 0);
        send_fields(OP_TAKE_FRONT, 0, 0, '0, 0);
    endtask

    // fill past capacity, erase the last slot of a full list, then drain
    task automatic test_capacity();
        sender_idle_pct = 10;
        recv_stall_pct  = 10;
        repeat (DEPTH + 2)
        begin
            send_cmd(rand_cmd($urandom_range(1) ? OP_ADD_FRONT : OP_ADD_BACK));
        end
        send_fields(OP_ERASE, 0, 0, '0, DEPTH - 1);
        send_cmd(rand_cmd(OP_ADD_BACK));
        send_cmd(rand_cmd(OP_FIND_TAG));
        send_cmd(rand_cmd(OP_FIND_XY));
        repeat (DEPTH + 1)
        begin
            send_cmd(rand_cmd($urandom_range(1) ? OP_TAKE_FRONT : OP_TAKE_BACK));
        end
    endtask

    // random items with the op mix switching every MIX_SPAN items
    task automatic test_random_mix(input int n_items, input int idle_pct,
                                   input int stall_pct);
        mix_t mix;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        mix             = MIX_GROW;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % MIX_SPAN == 0)
            begin
                mix = mix_t'($urandom_range(2));
            end
            send_cmd(rand_cmd(pick_op(mix)));
        end
    endtask

    // receiver holds off while the sender keeps pushing, so the input stalls
    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_requests++;
        repeat (30)
        begin
            send_cmd(rand_cmd(pick_op(MIX_EVEN)));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cmd_ch.valid    <= 1'b0;
        cmd_ch.op       <= OP_NOP;
        cmd_ch.x        <= '0;
        cmd_ch.y        <= '0;
        cmd_ch.tag      <= '0;
        cmd_ch.position <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();
        test_capacity();
        test_random_mix(470, 0, 0);
        test_random_mix(460, 81, 0);
        test_random_mix(460, 0, 81);
        test_random_mix(460, 26, 26);
        test_output_backpressure();
        cmd_ch.valid <= 1'b0;

        // wait for every outstanding result, then let the block settle
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d commands and %0d results, peak fill %0d of %0d",
                 items_accepted, results_checked, peak_fill, DEPTH);
        $display("error paths hit: %0d adds when full, %0d takes when empty, %0d misses, %s",
                 full_adds, empty_takes, search_misses,
                 $sformatf("%0d bad erases", range_erases));
        if (err_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
